@@ hdl/rau_pkg.sv @@
// ============================================================================
// rau_pkg
// shared constants, operation codes and controller/datapath command and status types
// ============================================================================
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int KIND_W            = 3;
    localparam int NUM_W             = 16;
    localparam int DEN_W             = 15;
    localparam int RES_NUM_W         = 32;
    localparam int RES_DEN_W         = 31;

    localparam logic [KIND_W-1:0] K_ADD = 3'd0;
    localparam logic [KIND_W-1:0] K_SUB = 3'd1;
    localparam logic [KIND_W-1:0] K_MUL = 3'd2;
    localparam logic [KIND_W-1:0] K_DIV = 3'd3;
    localparam logic [KIND_W-1:0] K_CMP = 3'd4;

    typedef struct packed {
        logic load;
        logic prod;
        logic combine;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_arith;
        logic is_zero;
        logic gcd_done;
        logic div_done;
        logic div_second;
    } t_status;

endpackage

@@ hdl/rau_datapath.sv @@
// ============================================================================
// rau_datapath
// operand products, euclid remainder by shift-subtract, reduction by the gcd
// ============================================================================
module rau_datapath #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  rau_pkg::t_cmd                      i_cmd,
    input  logic [rau_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [rau_pkg::NUM_W-1:0]   i_a_num,
    input  logic [rau_pkg::DEN_W-1:0]          i_a_den,
    input  logic signed [rau_pkg::NUM_W-1:0]   i_b_num,
    input  logic [rau_pkg::DEN_W-1:0]          i_b_den,
    output rau_pkg::t_status                   o_status,
    output logic signed [rau_pkg::RES_NUM_W-1:0] o_res_num,
    output logic [rau_pkg::RES_DEN_W-1:0]      o_res_den,
    output logic                               o_less,
    output logic                               o_equal,
    output logic                               o_greater,
    output logic                               o_div_zero
);
    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W + 1;
    localparam int CW = $clog2(PW + 1);

    logic [rau_pkg::KIND_W-1:0] r_kind;
    logic signed [W-1:0] r_an, r_bn;
    logic signed [W:0]   r_ad, r_bd;
    logic signed [PW-1:0] r_p1, r_p2, r_pd;
    logic [PW-1:0] r_un, r_ud, r_x, r_y, r_rem, r_q;
    logic [CW-1:0] r_cnt;
    logic r_neg, r_rem_busy, r_pass;

    logic signed [W-1:0] an_s, bn_s;
    logic [W-2:0] ad_m, bd_m;
    logic signed [PW-1:0] num_c, den_c;
    logic [PW-1:0] rem_sh, q_sh;

    assign an_s = W'(i_a_num);
    assign bn_s = W'(i_b_num);
    assign ad_m = (W-1)'(i_a_den);
    assign bd_m = (W-1)'(i_b_den);

    always_comb begin
        case (r_kind)
            rau_pkg::K_ADD: begin
                num_c = r_p1 + r_p2;
                den_c = r_pd;
            end
            rau_pkg::K_SUB: begin
                num_c = r_p1 - r_p2;
                den_c = r_pd;
            end
            default: begin
                num_c = r_p1;
                den_c = r_p2;
            end
        endcase
    end

    // euclid remainder r_x % r_y and reduction quotient share one restoring divider
    assign rem_sh = {r_rem[PW-2:0], r_q[PW-1]};
    assign q_sh   = {r_q[PW-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_an   <= an_s;
            r_bn   <= bn_s;
            r_ad   <= (ad_m == '0) ? (W+1)'(1) : $signed({2'b00, ad_m});
            r_bd   <= (bd_m == '0) ? (W+1)'(1) : $signed({2'b00, bd_m});
        end
        if (i_cmd.prod) begin
            case (r_kind)
                rau_pkg::K_MUL: begin
                    r_p1 <= PW'(r_an * r_bn);
                    r_p2 <= PW'(r_ad * r_bd);
                end
                rau_pkg::K_DIV: begin
                    r_p1 <= PW'(r_an * r_bd);
                    r_p2 <= PW'(r_ad * r_bn);
                end
                default: begin
                    r_p1 <= PW'(r_an * r_bd);
                    r_p2 <= PW'(r_bn * r_ad);
                end
            endcase
            r_pd <= PW'(r_ad * r_bd);
        end
        if (i_cmd.combine) begin
            r_neg <= (num_c < 0) != (den_c < 0);
            r_un  <= (num_c < 0) ? PW'(-num_c) : PW'(num_c);
            r_ud  <= (den_c < 0) ? PW'(-den_c) : PW'(den_c);
            r_x   <= (num_c < 0) ? PW'(-num_c) : PW'(num_c);
            r_y   <= (den_c < 0) ? PW'(-den_c) : PW'(den_c);
            r_rem_busy <= 1'b0;
            r_pass <= 1'b0;
        end
        if (i_cmd.gcd_step) begin
            if (!r_rem_busy) begin
                r_rem <= '0;
                r_q   <= r_x;
                r_cnt <= CW'(PW);
                r_rem_busy <= 1'b1;
            end else if (r_cnt != '0) begin
                r_rem <= (rem_sh >= r_y) ? rem_sh - r_y : rem_sh;
                r_q   <= q_sh | PW'(rem_sh >= r_y);
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_x <= r_y;
                r_y <= r_rem;
                r_rem_busy <= 1'b0;
            end
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_q   <= r_pass ? r_ud : r_un;
            r_cnt <= CW'(PW);
        end
        if (i_cmd.div_step) begin
            if (r_cnt != '0) begin
                r_rem <= (rem_sh >= r_x) ? rem_sh - r_x : rem_sh;
                r_q   <= q_sh | PW'(rem_sh >= r_x);
                r_cnt <= r_cnt - 1'b1;
            end else begin
                if (r_pass) r_ud <= r_q;
                else r_un <= r_q;
                r_pass <= ~r_pass;
            end
        end
        if (i_cmd.finish) begin
            o_res_num <= '0;
            o_res_den <= '0;
            o_less    <= 1'b0;
            o_equal   <= 1'b0;
            o_greater <= 1'b0;
            o_div_zero <= 1'b0;
            if (r_kind == rau_pkg::K_CMP) begin
                o_less    <= r_p1 < r_p2;
                o_equal   <= r_p1 == r_p2;
                o_greater <= r_p1 > r_p2;
            end else if (r_kind == rau_pkg::K_DIV && r_bn == '0) begin
                o_div_zero <= 1'b1;
            end else if (r_kind <= rau_pkg::K_DIV) begin
                if (r_un == '0) begin
                    o_res_den <= rau_pkg::RES_DEN_W'(1);
                end else begin
                    o_res_num <= r_neg ? rau_pkg::RES_NUM_W'(-r_un)
                                       : rau_pkg::RES_NUM_W'(r_un);
                    o_res_den <= rau_pkg::RES_DEN_W'(r_ud);
                end
            end
        end
    end

    assign o_status.is_arith   = (r_kind <= rau_pkg::K_DIV) &&
                                 !(r_kind == rau_pkg::K_DIV && r_bn == '0);
    assign o_status.is_zero    = (r_un == '0);
    assign o_status.gcd_done   = !r_rem_busy && (r_y == '0);
    assign o_status.div_done   = (r_cnt == '0);
    assign o_status.div_second = r_pass;
endmodule

@@ hdl/rau_ctrl.sv @@
// ============================================================================
// rau_ctrl
// sequencer for load, products, euclid loop and the two reducing divisions
// ============================================================================
module rau_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  rau_pkg::t_status i_status,
    output rau_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_PROD    = 8'b0000_0010,
        S_COMBINE = 8'b0000_0100,
        S_GCD     = 8'b0000_1000,
        S_DINIT   = 8'b0001_0000,
        S_DSTEP   = 8'b0010_0000,
        S_FINISH  = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) n_state = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state = S_COMBINE;
            end
            S_COMBINE: begin
                o_cmd.combine = 1'b1;
                n_state = S_GCD;
            end
            S_GCD: begin
                if (!i_status.is_arith || i_status.is_zero) n_state = S_FINISH;
                else if (i_status.gcd_done) n_state = S_DINIT;
                else o_cmd.gcd_step = 1'b1;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    if (i_status.div_second) n_state = S_FINISH;
                    else n_state = S_DINIT;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);
endmodule

@@ hdl/rational_arithmetic_unit.sv @@
// ============================================================================
// rational_arithmetic_unit
// fraction add, subtract, multiply, divide and compare with gcd reduction
// ============================================================================
// usage: drive the operands and i_kind, raise start while busy is low;
// that edge accepts the transaction and busy rises. the result shows on
// o_res_* and the flags for exactly one cycle with o_valid high, then busy
// falls. the receiver cannot stall; results must be taken as they appear.
// compare, divide-by-zero, zero result and unused codes skip the euclid
// loop. other arithmetic runs euclid with a 33-step remainder unit for
// each euclid step, then two divisions by the gcd. one transaction at
// a time.
// reset (synchronous, active low) returns the sequencer to idle; no result
// is pending afterward.
// ============================================================================
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic signed [15:0] i_a_num,
    input  logic [14:0] i_a_den,
    input  logic signed [15:0] i_b_num,
    input  logic [14:0] i_b_den,
    output logic        o_valid,
    output logic signed [31:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic        o_less,
    output logic        o_equal,
    output logic        o_greater,
    output logic        o_div_zero
);
    rau_pkg::t_cmd    cmd;
    rau_pkg::t_status status;

    rau_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_status(status),
        .o_cmd(cmd), .o_busy(busy), .o_done(o_valid)
    );

    rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_kind(i_kind),
        .i_a_num(i_a_num), .i_a_den(i_a_den),
        .i_b_num(i_b_num), .i_b_den(i_b_den),
        .o_status(status), .o_res_num(o_res_num), .o_res_den(o_res_den),
        .o_less(o_less), .o_equal(o_equal), .o_greater(o_greater),
        .o_div_zero(o_div_zero)
    );
endmodule

@@ hdl/rau_checker.sv @@
// ============================================================================
// rau_checker
// port-level checks on the start/busy handshake, result strobe and flag coding
// ============================================================================
module rau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [30:0] o_res_den,
    input logic        o_less,
    input logic        o_equal,
    input logic        o_greater,
    input logic        o_div_zero
);
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside transaction");
    a_valid_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_less, o_equal, o_greater, o_div_zero}))
        else $error("flag coding");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
    a_flag_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_less || o_equal || o_greater || o_div_zero))
        |-> o_res_den == '0) else $error("flag with fraction");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_res_den(o_res_den), .o_less(o_less),
    .o_equal(o_equal), .o_greater(o_greater), .o_div_zero(o_div_zero)
);

@@ tb/tb_rational_arithmetic_unit.sv @@
// ============================================================================
// tb_rational_arithmetic_unit
// self-checking bench for the fraction arithmetic and compare unit
// ============================================================================
// drives fraction pairs with every operation code through the start/busy
// handshake, predicts each reduced fraction or compare flag set in the
// bench, and checks every strobed result in order against the prediction
// ============================================================================
module tb_rational_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rau_pkg::KIND_W-1:0] K_LAST      = 3'd7;
    localparam int                         STALL_LIMIT = 20000;

    typedef struct {
        logic signed [rau_pkg::RES_NUM_W-1:0] num;
        logic [rau_pkg::RES_DEN_W-1:0]        den;
        logic                                 less;
        logic                                 equal;
        logic                                 greater;
        logic                                 div_zero;
    } t_fraction_result;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic [rau_pkg::KIND_W-1:0]        i_kind;
    logic signed [rau_pkg::NUM_W-1:0]  i_a_num;
    logic [rau_pkg::DEN_W-1:0]         i_a_den;
    logic signed [rau_pkg::NUM_W-1:0]  i_b_num;
    logic [rau_pkg::DEN_W-1:0]         i_b_den;
    logic                              o_valid;
    logic signed [31:0]                o_res_num;
    logic [30:0]                       o_res_den;
    logic                              o_less;
    logic                              o_equal;
    logic                              o_greater;
    logic                              o_div_zero;

    t_fraction_result expected_q[$];
    int               mismatches = 0;
    int               stall_cycles = 0;
    bit               idle_enable;
    bit               small_mode;

    rational_arithmetic_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_kind     (i_kind),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .o_valid    (o_valid),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_less     (o_less),
        .o_equal    (o_equal),
        .o_greater  (o_greater),
        .o_div_zero (o_div_zero)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void reduce_fraction(input longint n, input longint d,
                                            inout t_fraction_result r);
        bit                   neg;
        longint unsigned      un;
        longint unsigned      ud;
        longint unsigned      x;
        longint unsigned      y;
        longint unsigned      t;
        neg = (n < 0) != (d < 0);
        un  = (n < 0) ? -n : n;
        ud  = (d < 0) ? -d : d;
        if (un == 0) begin
            ud  = 1;
            neg = 1'b0;
        end else begin
            x = un;
            y = ud;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            un = un / x;
            ud = ud / x;
        end
        if (neg) un = -un;
        r.num = un[31:0];
        r.den = ud[30:0];
    endfunction

    function automatic t_fraction_result predict_fraction(
        input logic [rau_pkg::KIND_W-1:0] kind,
        input logic signed [rau_pkg::NUM_W-1:0] a_num,
        input logic [rau_pkg::DEN_W-1:0] a_den,
        input logic signed [rau_pkg::NUM_W-1:0] b_num,
        input logic [rau_pkg::DEN_W-1:0] b_den);
        t_fraction_result r;
        longint           an;
        longint           ad;
        longint           bn;
        longint           bd;
        r  = '{num: '0, den: '0, less: 1'b0, equal: 1'b0, greater: 1'b0,
               div_zero: 1'b0};
        an = a_num;
        bn = b_num;
        ad = (a_den == 0) ? 1 : a_den;
        bd = (b_den == 0) ? 1 : b_den;
        case (kind)
            rau_pkg::K_ADD: reduce_fraction(an * bd + bn * ad, ad * bd, r);
            rau_pkg::K_SUB: reduce_fraction(an * bd - bn * ad, ad * bd, r);
            rau_pkg::K_MUL: reduce_fraction(an * bn, ad * bd, r);
            rau_pkg::K_DIV: begin
                if (bn == 0) r.div_zero = 1'b1;
                else reduce_fraction(an * bd, ad * bn, r);
            end
            rau_pkg::K_CMP: begin
                if (an * bd < bn * ad) r.less = 1'b1;
                else if (an * bd == bn * ad) r.equal = 1'b1;
                else r.greater = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_fraction_op(input logic [rau_pkg::KIND_W-1:0] kind,
                                    input logic signed [rau_pkg::NUM_W-1:0] a_num,
                                    input logic [rau_pkg::DEN_W-1:0] a_den,
                                    input logic signed [rau_pkg::NUM_W-1:0] b_num,
                                    input logic [rau_pkg::DEN_W-1:0] b_den);
        start   <= 1'b1;
        i_kind  <= kind;
        i_a_num <= a_num;
        i_a_den <= a_den;
        i_b_num <= b_num;
        i_b_den <= b_den;
        do @(posedge i_clk); while (busy);
        expected_q.push_back(predict_fraction(kind, a_num, a_den, b_num, b_den));
        if (idle_enable && $urandom_range(0, 99) < 28) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic signed [rau_pkg::NUM_W-1:0] pick_numerator();
        logic signed [rau_pkg::NUM_W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 16'sh8000;
                    1: v = 16'sh7fff;
                    2: v = '0;
                    3: v = 16'sd1;
                    default: v = -16'sd1;
                endcase
            end
            1, 2, 3: v = $signed(rau_pkg::NUM_W'($urandom_range(0, 24))) - 16'sd12;
            default: v = small_mode
                         ? $signed(rau_pkg::NUM_W'($urandom_range(0, 40))) - 16'sd20
                         : rau_pkg::NUM_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [rau_pkg::DEN_W-1:0] pick_denominator();
        logic [rau_pkg::DEN_W-1:0] v;
        case ($urandom_range(0, 11))
            0: v = '0;
            1: v = {rau_pkg::DEN_W{1'b1}};
            2: v = rau_pkg::DEN_W'(1);
            3, 4, 5: v = rau_pkg::DEN_W'($urandom_range(1, 16));
            default: v = small_mode ? rau_pkg::DEN_W'($urandom_range(1, 30))
                                    : rau_pkg::DEN_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_random_ops(input int count);
        logic [rau_pkg::KIND_W-1:0] kind;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0)
                kind = rau_pkg::KIND_W'($urandom_range(rau_pkg::K_CMP + 1, K_LAST));
            else
                kind = rau_pkg::KIND_W'($urandom_range(rau_pkg::K_ADD, rau_pkg::K_CMP));
            send_fraction_op(kind, pick_numerator(), pick_denominator(),
                             pick_numerator(), pick_denominator());
        end
    endtask

    task automatic test_directed();
        for (int k = rau_pkg::K_ADD; k <= K_LAST; k++) begin
            send_fraction_op(rau_pkg::KIND_W'(k), 16'sd3, 15'd4, -16'sd5, 15'd6);
        end
        send_fraction_op(rau_pkg::K_ADD, 16'sh7fff, 15'h7fff, 16'sh7fff, 15'h7ffe);
        send_fraction_op(rau_pkg::K_SUB, 16'sh8000, 15'h7fff, 16'sh7fff, 15'd1);
        send_fraction_op(rau_pkg::K_MUL, 16'sh8000, 15'd1, 16'sh8000, 15'd1);
        send_fraction_op(rau_pkg::K_MUL, 16'sh8000, 15'h7fff, 16'sh7fff, 15'h7fff);
        send_fraction_op(rau_pkg::K_DIV, 16'sh7fff, 15'h7fff, 16'sh8000, 15'd1);
        send_fraction_op(rau_pkg::K_DIV, 16'sd5, 15'd7, 16'sd0, 15'd3);
        send_fraction_op(rau_pkg::K_DIV, 16'sd0, 15'd7, 16'sd0, 15'd0);
        send_fraction_op(rau_pkg::K_ADD, 16'sd1, 15'd2, -16'sd1, 15'd2);
        send_fraction_op(rau_pkg::K_SUB, 16'sd7, 15'd3, 16'sd14, 15'd6);
        send_fraction_op(rau_pkg::K_ADD, 16'sd3, 15'd0, 16'sd1, 15'd0);
        send_fraction_op(rau_pkg::K_CMP, 16'sd2, 15'd4, 16'sd1, 15'd2);
        send_fraction_op(rau_pkg::K_CMP, -16'sd1, 15'd3, 16'sd0, 15'd0);
        send_fraction_op(rau_pkg::K_CMP, 16'sh7fff, 15'd1, 16'sh8000, 15'd1);
        send_fraction_op(rau_pkg::K_CMP, 16'sd0, 15'd5, 16'sd0, 15'd9);
        send_fraction_op(rau_pkg::K_MUL, -16'sd6, 15'd4, 16'sd0, 15'd1);
        send_fraction_op(rau_pkg::K_DIV, -16'sd6, 15'd4, -16'sd9, 15'd2);
        wait_results_drained();
    endtask

    task automatic test_random_full();
        small_mode = 1'b0;
        send_random_ops(800);
        wait_results_drained();
    endtask

    task automatic test_small_values();
        small_mode = 1'b1;
        send_random_ops(500);
        wait_results_drained();
    endtask

    task automatic test_back_to_back();
        idle_enable = 1'b0;
        small_mode  = 1'b0;
        send_random_ops(380);
        idle_enable = 1'b1;
        wait_results_drained();
    endtask

    always @(posedge i_clk) begin
        t_fraction_result e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction");
            end else begin
                e = expected_q.pop_front();
                if (o_res_num !== e.num || o_res_den !== e.den || o_less !== e.less ||
                    o_equal !== e.equal || o_greater !== e.greater ||
                    o_div_zero !== e.div_zero) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d %b%b%b%b got %0d/%0d %b%b%b%b",
                                 e.num, e.den, e.less, e.equal, e.greater, e.div_zero,
                                 o_res_num, o_res_den, o_less, o_equal, o_greater,
                                 o_div_zero);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        idle_enable  = 1'b1;
        small_mode   = 1'b0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_kind      <= rau_pkg::K_ADD;
        i_a_num     <= '0;
        i_a_den     <= rau_pkg::DEN_W'(1);
        i_b_num     <= '0;
        i_b_den     <= rau_pkg::DEN_W'(1);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_full();
        test_small_values();
        test_back_to_back();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
